/* hdl/pli_pkg.sv */
// Shared types, codes and constants for the positional list block.
package pli_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int ENTRY_WIDTH_DEF = 32;
  localparam int KIND_W          = 3;
  localparam int POS_W           = 7;
  localparam int VALUE_W         = 32;
  localparam int STATUS_W        = 2;
  localparam int COUNT_W         = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FIRST = 3'd0,
    KIND_INS_LAST  = 3'd1,
    KIND_INS_AT    = 3'd2,
    KIND_DEL_FIRST = 3'd3,
    KIND_DEL_LAST  = 3'd4,
    KIND_DEL_AT    = 3'd5,
    KIND_DUMP      = 3'd6,
    KIND_CLEAR     = 3'd7
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    DP_HOLD,
    DP_INS,
    DP_DEL,
    DP_CLEAR,
    DP_ROT
  } dp_op_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]  entry_count;
    logic                last_result;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t              op;
    logic [POS_W-1:0]    idx;
    logic [VALUE_W-1:0]  value;
    logic                dump_start;
    logic                load_out;
    logic                out_dump;
    logic [STATUS_W-1:0] out_status;
    logic                out_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic               full;
    logic               rem_last;
  } dp_stat_t;

endpackage

/* hdl/pli_datapath.sv */
// Datapath: chain of entry cells, count, dump counter and result register.
module pli_datapath import pli_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [ENTRY_WIDTH-1:0] cell_r   [CAPACITY];
  logic [ENTRY_WIDTH-1:0] cell_nxt [CAPACITY];
  logic [ENTRY_WIDTH-1:0] ins_val;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  out_item_t              out_r, out_nxt;

  assign ins_val = ENTRY_WIDTH'(cmd.value);

  // each cell looks only at its neighbours, the new value and cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] below, above;
    if (i == 0) begin : g_first
      assign below = cell_r[i];
    end else begin : g_below
      assign below = cell_r[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign above = cell_r[i];
    end else begin : g_above
      assign above = cell_r[i+1];
    end

    always_comb begin
      unique case (cmd.op)
        DP_INS: begin
          if (POS_W'(i) > cmd.idx) cell_nxt[i] = below;
          else if (POS_W'(i) == cmd.idx) cell_nxt[i] = ins_val;
          else cell_nxt[i] = cell_r[i];
        end
        DP_DEL: begin
          if (POS_W'(i) >= cmd.idx) cell_nxt[i] = above;
          else cell_nxt[i] = cell_r[i];
        end
        DP_ROT: begin
          // wrap the head round to the tail of the held entries
          if (CNT_W'(i + 1) == count_r) cell_nxt[i] = cell_r[0];
          else cell_nxt[i] = above;
        end
        default: cell_nxt[i] = cell_r[i];
      endcase
    end

    always_ff @(posedge clk) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  always_comb begin
    unique case (cmd.op)
      DP_INS:   count_nxt = count_r + CNT_W'(1);
      DP_DEL:   count_nxt = count_r - CNT_W'(1);
      DP_CLEAR: count_nxt = '0;
      default:  count_nxt = count_r;
    endcase

    rem_nxt = rem_r;
    if (cmd.dump_start) rem_nxt = count_r;
    else if (cmd.op == DP_ROT) rem_nxt = rem_r - CNT_W'(1);

    out_nxt = out_r;
    if (cmd.load_out) begin
      out_nxt.status      = cmd.out_status;
      out_nxt.read_value  = cmd.out_dump ? VALUE_W'(cell_r[0]) : '0;
      out_nxt.entry_count = COUNT_W'(count_nxt);
      out_nxt.last_result = cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rem_r   <= '0;
    end else begin
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
    end
    out_r <= out_nxt;
  end

  assign stat.count    = COUNT_W'(count_r);
  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_r >= CNT_W'(CAPACITY));
  assign stat.rem_last = (rem_r == CNT_W'(1));
  assign out_item      = out_r;

endmodule

/* hdl/pli_ctrl.sv */
// Controller: decodes transactions, checks limits and sequences dumps.
module pli_ctrl import pli_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free, accept;
  logic   pos_ins_ok, pos_del_ok;
  logic [POS_W:0] pos_x, cnt_x;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;

  assign pos_x      = {1'b0, in_item.position};
  assign cnt_x      = (POS_W + 1)'(stat.count);
  assign pos_ins_ok = (pos_x != '0) && (pos_x <= cnt_x + (POS_W + 1)'(1));
  assign pos_del_ok = (pos_x != '0) && (pos_x <= cnt_x);

  always_comb begin
    cmd            = '0;
    cmd.op         = DP_HOLD;
    cmd.value      = in_item.entry_value;
    cmd.out_status = ST_OK;
    cmd.out_last   = 1'b1;
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          unique case (in_item.kind)
            KIND_INS_FIRST, KIND_INS_LAST, KIND_INS_AT: begin
              if (stat.full) begin
                cmd.out_status = ST_FULL;
              end else if (in_item.kind == KIND_INS_FIRST) begin
                cmd.op  = DP_INS;
                cmd.idx = '0;
              end else if (in_item.kind == KIND_INS_LAST) begin
                cmd.op  = DP_INS;
                cmd.idx = stat.count;
              end else if (pos_ins_ok) begin
                cmd.op  = DP_INS;
                cmd.idx = in_item.position - POS_W'(1);
              end else begin
                cmd.out_status = ST_BADPOS;
              end
            end
            KIND_DEL_FIRST, KIND_DEL_LAST, KIND_DEL_AT: begin
              if (stat.empty) begin
                cmd.out_status = ST_EMPTY;
              end else if (in_item.kind == KIND_DEL_FIRST) begin
                cmd.op  = DP_DEL;
                cmd.idx = '0;
              end else if (in_item.kind == KIND_DEL_LAST) begin
                cmd.op  = DP_DEL;
                cmd.idx = stat.count - POS_W'(1);
              end else if (pos_del_ok) begin
                cmd.op  = DP_DEL;
                cmd.idx = in_item.position - POS_W'(1);
              end else begin
                cmd.out_status = ST_BADPOS;
              end
            end
            KIND_DUMP: begin
              if (stat.empty) begin
                cmd.out_status = ST_EMPTY;
              end else begin
                // no result yet: the entries follow one per cycle while the result register is free
                cmd.load_out   = 1'b0;
                cmd.dump_start = 1'b1;
                out_valid_nxt  = out_valid_r && !out_ready;
                state_nxt      = S_DUMP;
              end
            end
            KIND_CLEAR: cmd.op = DP_CLEAR;
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          cmd.op        = DP_ROT;
          cmd.load_out  = 1'b1;
          cmd.out_dump  = 1'b1;
          cmd.out_last  = stat.rem_last;
          out_valid_nxt = 1'b1;
          if (stat.rem_last) state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/positional_list_insert_delete.sv */
// Top level of the bounded positional list.
// An ordered list of up to CAPACITY entries of ENTRY_WIDTH bits, held in a chain of
// cells written at once on an insert, delete or clear; a new transaction is accepted
// each cycle while the result register is free or being drained. A dump holds the
// input while it runs: it first loads the dump counter, then gives one result per
// cycle while the result register is free or being drained, as the chain rotates its
// head out through the result register; an empty dump gives a single EMPTY result.
// Results pass through a single output register, so the next transaction is taken
// only in a cycle where that register is empty or its result leaves; a stalled result
// holds the input. Entries keep the low ENTRY_WIDTH bits of entry_value.
module positional_list_insert_delete import pli_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pli_datapath #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

/* hdl/pli_checker.sv */
// Port-level checks for the positional list, bound to the top level.
module pli_checker import pli_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // a waiting transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("input changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // never take a transaction while the result register stays full
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready)
    else $error("input taken with result register blocked");

  // only dump results can be followed by more results of the same transaction
  a_mid_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_result |->
      out_item.status == ST_OK && out_item.entry_count != '0)
    else $error("non-final result outside a dump");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.entry_count <= COUNT_W'(CAPACITY))
    else $error("count above capacity");

endmodule

bind positional_list_insert_delete pli_checker #(.CAPACITY(CAPACITY)) u_pli_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
